FILE: hw/rtl/checked_integer_alu_assert.svh
// Assertion macros for the checked integer ALU.
// Used by the top level; no other dependencies.
`ifndef CHECKED_INTEGER_ALU_ASSERT_SVH
`define CHECKED_INTEGER_ALU_ASSERT_SVH
`ifndef SYNTHESIS
`define CIA_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define CIA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define CIA_ASSERT_IMPL(label, clk, rst_n, prop)
`define CIA_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: hw/rtl/cia_pkg.sv
// Package for the checked integer ALU: opcodes, status codes, word types.
// No dependencies.
package cia_pkg;
    localparam int unsigned XLEN = 64;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
        OP_REM = 5'd5, OP_AND = 5'd6, OP_OR = 5'd7, OP_XOR = 5'd8, OP_LSH = 5'd9,
        OP_RSH = 5'd10, OP_ASH = 5'd11, OP_NOT = 5'd12, OP_EQ = 5'd13, OP_NE = 5'd14,
        OP_LT = 5'd15, OP_LE = 5'd16, OP_GT = 5'd17, OP_GE = 5'd18, OP_LNOT = 5'd19,
        OP_UADD = 5'd20, OP_USUB = 5'd21, OP_UMUL = 5'd22, OP_UDIV = 5'd23,
        OP_UMOD = 5'd24, OP_ULT = 5'd25, OP_ULE = 5'd26, OP_UGT = 5'd27,
        OP_UGE = 5'd28
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        logic [4:0]         command;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic [1:0]         status;
    } t_out_word;

    // Word that rides along the cell chain.
    typedef struct packed {
        logic        vld;
        logic [4:0]  cmd;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] dvs;     // divisor magnitude
        logic [63:0] quo;     // quotient bits, also dividend shift
        logic [63:0] rem;     // partial remainder
        logic [1:0]  mlo;     // unused bits, kept narrow
        logic [127:0] prd;    // product accumulator
        logic [63:0] res;     // early result for simple ops
        logic [1:0]  st;
    } t_cell;
endpackage

FILE: hw/rtl/checked_integer_alu.sv
// Checked 64-bit integer ALU: a decode stage, a chain of 64 cells (divide
// and multiply steps) and a result stage with skid input. Depends on cia_pkg.
//
// The ALU accepts one word per cycle while the skid register is empty. A word
// passes through 66 register stages: one decode stage, 64 cells, each
// retiring one quotient bit, and the output register fed by the finish logic.
// Multiplication is done in the first four cells as 16-bit slices. The chain
// stalls only when the output register is full and not taken; a skid register
// holds an input word that arrives during a stall, and input ready is low
// while it is full.
`include "checked_integer_alu_assert.svh"
module checked_integer_alu
    import cia_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);
    localparam int unsigned NCELL = 64;

    t_cell     chain [NCELL+1];
    t_cell     n_head;
    t_in_word  r_skid;
    logic      r_skid_vld;
    t_in_word  cur;
    logic      cur_vld;
    logic      adv;
    t_out_word r_out;
    logic      r_out_vld;
    t_out_word n_out;
    t_cell     r_head;

    // Chain moves when output slot is free or being taken.
    assign adv     = !r_out_vld || i_ready;
    assign o_ready = !r_skid_vld;
    assign cur     = r_skid_vld ? r_skid : i_data;
    assign cur_vld = r_skid_vld || i_valid;

    // Hold an input word that arrives while the chain is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (adv) begin
            r_skid_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_skid_vld <= 1'b1;
        end
        if (!adv && i_valid && o_ready) begin
            r_skid <= i_data;
        end
    end

    // Decode: simple ops finish here, dividend and divisor magnitudes are prepared.
    always_comb begin
        logic [63:0] a;
        logic [63:0] b;
        logic        sgn;
        logic [63:0] sum;
        logic [63:0] dif;
        logic        slt_ab;
        logic        slt_ba;
        logic        bbig;
        a = cur.operand_a;
        b = cur.operand_b;
        sgn = (cur.command == OP_DIV) || (cur.command == OP_MOD) ||
              (cur.command == OP_REM);
        sum = a + b;
        dif = a - b;
        slt_ab = (a ^ 64'h8000_0000_0000_0000) < (b ^ 64'h8000_0000_0000_0000);
        slt_ba = (b ^ 64'h8000_0000_0000_0000) < (a ^ 64'h8000_0000_0000_0000);
        bbig = |b[63:6];
        n_head = '0;
        n_head.vld = cur_vld;
        n_head.cmd = cur.command;
        n_head.a   = a;
        n_head.b   = b;
        n_head.quo = (sgn && a[63]) ? (64'd0 - a) : a;
        n_head.dvs = (sgn && b[63]) ? (64'd0 - b) : b;
        n_head.res = '0;
        n_head.st  = ST_OK;
        case (t_op'(cur.command))
            OP_ADD: begin
                n_head.res = sum;
                if ((((a ^ sum) & (b ^ sum)) >> 63) != 64'd0) n_head.st = ST_OVF;
            end
            OP_SUB: begin
                n_head.res = dif;
                if ((((a ^ b) & (a ^ dif)) >> 63) != 64'd0) n_head.st = ST_OVF;
            end
            OP_UADD: n_head.res = sum;
            OP_USUB: n_head.res = dif;
            OP_AND:  n_head.res = a & b;
            OP_OR:   n_head.res = a | b;
            OP_XOR:  n_head.res = a ^ b;
            OP_LSH:  n_head.res = bbig ? 64'd0 : (a << b[5:0]);
            OP_RSH:  n_head.res = bbig ? 64'd0 : (a >> b[5:0]);
            OP_ASH:  n_head.res = bbig ? {64{a[63]}} :
                                  64'($signed(a) >>> b[5:0]);
            OP_NOT:  n_head.res = ~a;
            OP_EQ:   n_head.res = 64'(a == b);
            OP_NE:   n_head.res = 64'(a != b);
            OP_LT:   n_head.res = 64'(slt_ab);
            OP_LE:   n_head.res = 64'(!slt_ba);
            OP_GT:   n_head.res = 64'(slt_ba);
            OP_GE:   n_head.res = 64'(!slt_ab);
            OP_LNOT: n_head.res = 64'(a == 64'd0);
            OP_ULT:  n_head.res = 64'(a < b);
            OP_ULE:  n_head.res = 64'(a <= b);
            OP_UGT:  n_head.res = 64'(a > b);
            OP_UGE:  n_head.res = 64'(a >= b);
            default: n_head.res = '0;
        endcase
    end

    // Register the decoded word at the head of the chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.vld <= 1'b0;
        end else if (adv) begin
            r_head.vld <= n_head.vld;
        end
        if (adv) begin
            r_head.cmd <= n_head.cmd;
            r_head.a   <= n_head.a;
            r_head.b   <= n_head.b;
            r_head.dvs <= n_head.dvs;
            r_head.quo <= n_head.quo;
            r_head.rem <= n_head.rem;
            r_head.mlo <= n_head.mlo;
            r_head.prd <= n_head.prd;
            r_head.res <= n_head.res;
            r_head.st  <= n_head.st;
        end
    end

    assign chain[0] = r_head;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        cia_cell #(.IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_cell (chain[g]),
            .o_cell (chain[g+1])
        );
    end

    // Finish: signs, special cases and overflow of mul/div.
    always_comb begin
        t_cell       t;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] sq;
        logic [63:0] sr;
        logic [63:0] mb;
        logic [63:0] ph;
        logic        neg;
        logic        mov;
        t = chain[NCELL];
        a = t.a;
        b = t.b;
        q = t.quo;
        r = t.rem;
        mb = t.dvs;
        neg = a[63] ^ b[63];
        sq = neg ? (64'd0 - q) : q;
        sr = a[63] ? (64'd0 - r) : r;
        // Turn the unsigned product's high half into the signed one; the
        // signed product fits in 64 bits only if that half is the sign fill.
        ph = t.prd[127:64] - (a[63] ? b : 64'd0) - (b[63] ? a : 64'd0);
        mov = (ph != {64{t.prd[63]}});
        n_out.result_value = t.res;
        n_out.status       = t.st;
        case (t_op'(t.cmd))
            OP_MUL: begin
                n_out.result_value = t.prd[63:0];
                n_out.status = mov ? ST_OVF : ST_OK;
            end
            OP_UMUL: n_out.result_value = t.prd[63:0];
            OP_DIV: begin
                if (b == 64'd0) begin
                    n_out.result_value = '0;
                    n_out.status = ST_DIV0;
                end else begin
                    n_out.result_value = sq;
                    n_out.status = (a == 64'h8000_0000_0000_0000 && b == '1)
                                   ? ST_OVF : ST_OK;
                end
            end
            OP_MOD: begin
                if (b == 64'd0) begin
                    n_out.result_value = '0;
                    n_out.status = ST_DIV0;
                end else begin
                    n_out.result_value = sr[63] ? (sr + mb) : sr;
                end
            end
            OP_REM: begin
                if (b == 64'd0) n_out.result_value = a;
                else if (b == '1) n_out.result_value = '0;
                else n_out.result_value = sr;
            end
            OP_UDIV: begin
                if (b == 64'd0) begin
                    n_out.result_value = '0;
                    n_out.status = ST_DIV0;
                end else begin
                    n_out.result_value = q;
                end
            end
            OP_UMOD: n_out.result_value = (b == 64'd0) ? a : r;
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= chain[NCELL].vld;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    `CIA_ASSERT_IMPL(a_skid_only_stall, i_clk, i_rst_n, r_skid_vld |-> !adv || $past(!adv))
    `CIA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
    `CIA_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, o_valid |-> o_data.status != 2'd3)
endmodule

FILE: hw/rtl/cia_cell.sv
// One cell of the ALU chain: one restoring divide step, and in the first
// four cells one 16-bit multiplier partial product. Depends on cia_pkg.
module cia_cell
    import cia_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_cell  i_cell,
    output t_cell  o_cell
);
    localparam int unsigned MSTEP = IDX / 4;
    localparam int unsigned MSUB  = IDX % 4;

    t_cell        r_cell;
    t_cell        n_cell;
    logic [64:0]  rsh;
    logic [64:0]  diff;
    logic [79:0]  pp;

    // One divide step plus one 64x16 partial product when this cell owns one.
    always_comb begin
        n_cell = i_cell;
        rsh    = {i_cell.rem, i_cell.quo[63]};
        diff   = rsh - {1'b0, i_cell.dvs};
        n_cell.quo = {i_cell.quo[62:0], ~diff[64]};
        n_cell.rem = diff[64] ? rsh[63:0] : diff[63:0];
        pp = 80'(i_cell.a) * 80'(i_cell.b[16*MSUB +: 16]);
        if (MSTEP == 0 && IDX < 4) begin
            n_cell.prd = i_cell.prd + (128'(pp) << (16 * MSUB));
        end
        n_cell.mlo = i_cell.mlo;
    end

    // Advance the word when the chain moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell.vld <= i_cell.vld;
        end
        if (i_en) begin
            r_cell.cmd <= n_cell.cmd;
            r_cell.a   <= n_cell.a;
            r_cell.b   <= n_cell.b;
            r_cell.dvs <= n_cell.dvs;
            r_cell.quo <= n_cell.quo;
            r_cell.rem <= n_cell.rem;
            r_cell.mlo <= n_cell.mlo;
            r_cell.prd <= n_cell.prd;
            r_cell.res <= n_cell.res;
            r_cell.st  <= n_cell.st;
        end
    end

    assign o_cell = r_cell;
endmodule

FILE: tb/tb_checked_integer_alu.sv
// Testbench for checked_integer_alu: directed and random words checked against
// a predictor of the 64-bit ALU. Depends on cia_pkg and the ALU RTL.
module tb_checked_integer_alu;
    import cia_pkg::*;

    localparam int LATENCY   = 66;
    localparam int MAX_CYCLE = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_data;

    t_out_word expected_words[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_off;
    int        failures = 0;
    longint    cycle_count = 0;

    checked_integer_alu i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Generate the clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic logic [63:0] magnitude(logic [63:0] x);
        return x[63] ? -x : x;
    endfunction

    function automatic bit signed_less(logic [63:0] a, logic [63:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [63:0] trunc_rem(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = magnitude(a) % magnitude(b);
        return a[63] ? -r : r;
    endfunction

    // Compute the expected ALU result for one word
    function automatic t_out_word alu_result(t_in_word w);
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  r;
        logic [1:0]   st;
        logic [127:0] full;
        logic [63:0]  q;
        a  = w.operand_a;
        b  = w.operand_b;
        r  = '0;
        st = ST_OK;
        case (w.command)
            OP_ADD: begin
                r = a + b;
                if ((a[63] == b[63]) && (r[63] != a[63])) st = ST_OVF;
            end
            OP_SUB: begin
                r = a - b;
                if ((a[63] != b[63]) && (r[63] != a[63])) st = ST_OVF;
            end
            OP_MUL: begin
                full = $signed(a) * $signed(b);
                r = full[63:0];
                if (full[127:63] != {65{full[63]}}) st = ST_OVF;
            end
            OP_DIV: begin
                if (b == 0) st = ST_DIV0;
                else begin
                    q = magnitude(a) / magnitude(b);
                    r = (a[63] ^ b[63]) ? -q : q;
                    if (a == 64'h8000000000000000 && b == '1) st = ST_OVF;
                end
            end
            OP_MOD: begin
                if (b == 0) st = ST_DIV0;
                else begin
                    r = trunc_rem(a, b);
                    if (r[63]) r = r + magnitude(b);
                end
            end
            OP_REM: begin
                if (b == 0) r = a;
                else if (b == '1) r = '0;
                else r = trunc_rem(a, b);
            end
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_LSH:  r = (b >= 64) ? '0 : a << b[5:0];
            OP_RSH:  r = (b >= 64) ? '0 : a >> b[5:0];
            OP_ASH: begin
                if (b >= 64) r = {64{a[63]}};
                else r = $signed(a) >>> b[5:0];
            end
            OP_NOT:  r = ~a;
            OP_EQ:   r = 64'(a == b);
            OP_NE:   r = 64'(a != b);
            OP_LT:   r = 64'(signed_less(a, b));
            OP_LE:   r = 64'(!signed_less(b, a));
            OP_GT:   r = 64'(signed_less(b, a));
            OP_GE:   r = 64'(!signed_less(a, b));
            OP_LNOT: r = 64'(a == 0);
            OP_UADD: r = a + b;
            OP_USUB: r = a - b;
            OP_UMUL: r = a * b;
            OP_UDIV: begin
                if (b == 0) st = ST_DIV0;
                else r = a / b;
            end
            OP_UMOD: r = (b == 0) ? a : a % b;
            OP_ULT:  r = 64'(a < b);
            OP_ULE:  r = 64'(a <= b);
            OP_UGT:  r = 64'(a > b);
            OP_UGE:  r = 64'(a >= b);
            default: r = '0;
        endcase
        return '{result_value: r, status: st};
    endfunction

    // Pick an operand biased toward corner values
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 64'h8000000000000000;
            1: return 64'h7FFFFFFFFFFFFFFF;
            2: return '1;
            3: return '0;
            4: return 64'($urandom_range(0, 70));
            5: return -64'($urandom_range(1, 300));
            6: return {32'(0), $urandom()};
            7: return {{32{1'b1}}, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Send one word, idling first at the current rate; valid stays high after
    // acceptance until the next idle cycle or the next word replaces it
    task automatic send_word(logic [4:0] cmd, logic [63:0] a, logic [63:0] b);
        t_in_word w;
        w = '{command: cmd, operand_a: a, operand_b: b};
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        expected_words.push_back(alu_result(w));
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_random(int n);
        repeat (n) send_word(5'($urandom_range(0, 31)), pick_operand(), pick_operand());
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    // Corner cases of selected operations and one undefined opcode
    task automatic test_directed();
        send_word(OP_ADD, 64'h7FFFFFFFFFFFFFFF, 64'd1);
        send_word(OP_SUB, 64'h8000000000000000, 64'd1);
        send_word(OP_MUL, 64'h4000000000000000, 64'd2);
        send_word(OP_MUL, 64'h8000000000000000, '1);
        send_word(OP_DIV, 64'h8000000000000000, '1);
        send_word(OP_DIV, 64'd5, 64'd0);
        send_word(OP_MOD, -64'sd7, 64'd3);
        send_word(OP_MOD, 64'd7, 64'd0);
        send_word(OP_MOD, 64'h8000000000000000, '1);
        send_word(OP_MOD, -64'sd1, 64'h8000000000000000);
        send_word(OP_REM, 64'd9, 64'd0);
        send_word(OP_REM, 64'h8000000000000000, '1);
        send_word(OP_REM, -64'sd9, 64'd4);
        send_word(OP_LSH, '1, 64'd64);
        send_word(OP_RSH, '1, 64'd63);
        send_word(OP_ASH, 64'h8000000000000000, '1);
        send_word(OP_ASH, 64'h8000000000000000, 64'd0);
        send_word(OP_NOT, '0, '0);
        send_word(OP_LT, 64'h8000000000000000, 64'd0);
        send_word(OP_LNOT, '0, '1);
        send_word(OP_UDIV, '1, 64'd0);
        send_word(OP_UMOD, 64'd11, 64'd0);
        send_word(OP_ULT, 64'h8000000000000000, 64'd0);
        send_word(OP_GE, '1, '1);
        send_word(5'd31, '1, '1);
    endtask

    // Each operation once at random
    task automatic test_all_ops();
        for (int op = 0; op < 32; op++) send_word(5'(op), pick_operand(), pick_operand());
    endtask

    task automatic test_idle_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;  send_random(450);
        send_idle_pct = 60; recv_stall_pct = 0;  send_random(450);
        send_idle_pct = 0;  recv_stall_pct = 60; send_random(450);
        send_idle_pct = 23; recv_stall_pct = 23; send_random(450);
    endtask

    // Hold off the receiver long enough for the chain to fill
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off = 1'b1;
        send_random(100);
    endtask

    // Receiver ready, with stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Count the hold-off stretch and release it
    initial begin
        wait (hold_off);
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result %h", o_data);
                failures++;
            end else begin
                exp_word = expected_words.pop_front();
                if (o_data.result_value !== exp_word.result_value) begin
                    $error("result_value: expected %h actual %h",
                           exp_word.result_value, o_data.result_value);
                    failures++;
                end
                if (o_data.status !== exp_word.status) begin
                    $error("status: expected %0d actual %0d", exp_word.status, o_data.status);
                    failures++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLE) begin
            $display("tb_checked_integer_alu: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_all_ops();
        test_idle_phases();
        test_backpressure();
        // Drop valid once the last word is taken
        i_valid <= 1'b0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (failures == 0 && expected_words.size() == 0) begin
            $display("tb_checked_integer_alu: PASS");
        end else begin
            $display("tb_checked_integer_alu: FAIL");
        end
        $finish;
    end
endmodule
